// ===== design/usp_pkg.sv =====
// Shared types, constants and the arctangent table of the UV-sphere mesh generator.
package usp_pkg;

    localparam int CUT_W     = 10;
    localparam int IDX_W     = 20;
    localparam int TEX_W     = 17;
    localparam int ROT_W     = 34;
    localparam int QUO_W     = 34;
    localparam int DIV_CELLS = 33;

    localparam logic [ROT_W-1:0] CORDIC_K     = 34'h026DD3B6A;
    localparam logic [ROT_W-1:0] QUARTER_TURN = 34'h040000000;
    localparam logic [ROT_W-1:0] HALF_TURN    = 34'h080000000;

    typedef enum logic [2:0] {
        REG_RADIUS   = 3'd0,
        REG_H_CUTS   = 3'd1,
        REG_V_CUTS   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_TINT     = 3'd6
    } t_reg_idx;

    // partial remainders and quotient bits of the two divisions (segment/h, ring/v)
    typedef struct packed {
        logic [CUT_W-1:0] rem_h;
        logic [CUT_W-1:0] rem_v;
        logic [QUO_W-1:0] q_h;
        logic [QUO_W-1:0] q_v;
    } t_div;

    typedef struct packed {
        logic [ROT_W-1:0] x;
        logic [ROT_W-1:0] y;
        logic [ROT_W-1:0] z;
    } t_lane;

    // elevation lane and azimuth lane of the rotator
    typedef struct packed {
        t_lane elev;
        t_lane azim;
    } t_rot;

    typedef struct packed {
        logic             valid;
        logic             req_type;
        logic             bad;
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] i2;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             neg_e;
        logic             neg_a;
    } t_side;

    function automatic logic [ROT_W-1:0] usp_atan(input int k);
        case (k)
            0:       return 34'h020000000;
            1:       return 34'h012E4051E;
            2:       return 34'h009FB385B;
            3:       return 34'h0051111D4;
            4:       return 34'h0028B0D43;
            5:       return 34'h00145D7E1;
            6:       return 34'h000A2F61E;
            7:       return 34'h000517C55;
            8:       return 34'h00028BE53;
            9:       return 34'h000145F2F;
            10:      return 34'h0000A2F98;
            11:      return 34'h0000517CC;
            12:      return 34'h000028BE6;
            13:      return 34'h0000145F3;
            14:      return 34'h00000A2FA;
            15:      return 34'h00000517D;
            16:      return 34'h0000028BE;
            17:      return 34'h00000145F;
            18:      return 34'h000000A30;
            19:      return 34'h000000518;
            20:      return 34'h00000028C;
            21:      return 34'h000000146;
            22:      return 34'h0000000A3;
            23:      return 34'h000000051;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== design/usp_div_cell.sv =====
// One restoring-division cell: one quotient bit for each of the two divisions.
module usp_div_cell
    import usp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [CUT_W-1:0] i_den_h,
    input  logic [CUT_W-1:0] i_den_v,
    input  t_div             i_div,
    output t_div             o_div
);

    logic [CUT_W:0] w_th;
    logic [CUT_W:0] w_tv;
    logic           w_ge_h;
    logic           w_ge_v;
    t_div           n_div;
    t_div           r_div;

    always_comb begin
        w_th   = {i_div.rem_h, 1'b0};
        w_tv   = {i_div.rem_v, 1'b0};
        w_ge_h = (w_th >= {1'b0, i_den_h});
        w_ge_v = (w_tv >= {1'b0, i_den_v});
        n_div.rem_h = w_ge_h ? CUT_W'(w_th - {1'b0, i_den_h}) : CUT_W'(w_th);
        n_div.rem_v = w_ge_v ? CUT_W'(w_tv - {1'b0, i_den_v}) : CUT_W'(w_tv);
        n_div.q_h   = {i_div.q_h[QUO_W-2:0], w_ge_h};
        n_div.q_v   = {i_div.q_v[QUO_W-2:0], w_ge_v};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

// ===== design/usp_cordic_cell.sv =====
// One CORDIC rotation cell, elevation and azimuth lanes side by side.
module usp_cordic_cell
    import usp_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic i_clk,
    input  logic i_en,
    input  t_rot i_rot,
    output t_rot o_rot
);

    localparam logic [ROT_W-1:0] ATAN = usp_atan(STAGE);

    t_rot n_rot;
    t_rot r_rot;

    function automatic t_lane rot_step(input t_lane a);
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic signed [ROT_W-1:0] xs;
        logic signed [ROT_W-1:0] ys;
        t_lane                   r;
        x  = $signed(a.x);
        y  = $signed(a.y);
        z  = $signed(a.z);
        xs = x >>> STAGE;
        ys = y >>> STAGE;
        if (!z[ROT_W-1]) begin
            r.x = x - ys;
            r.y = y + xs;
            r.z = z - $signed(ATAN);
        end else begin
            r.x = x + ys;
            r.y = y - xs;
            r.z = z + $signed(ATAN);
        end
        return r;
    endfunction

    always_comb begin
        n_rot.elev = rot_step(i_rot.elev);
        n_rot.azim = rot_step(i_rot.azim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

// ===== design/uv_sphere_mesh_generator_core.sv =====
// Throughput: one vertex request per cycle while the output is taken; a quad request holds the output for two words.
// The pipeline is a chain of 33 divider cells and TRIG_STAGES CORDIC cells under one enable,
// which stalls while the output register holds a word that is not yet taken or a quad's second triangle is pending.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module uv_sphere_mesh_generator_core
    import usp_pkg::*;
#(
    parameter int MAX_CUTS    = 1024,
    parameter int TRIG_STAGES = 16
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // ring[9:0], segment[19:10], zero pad
    input  logic         s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, vertex_color, tri_a, tri_b, tri_c, zero pad
    output logic [223:0] m_axis_tdata,
    output logic         m_axis_tuser,   // bad_request
    output logic         m_axis_tlast
);

    localparam int P_A   = DIV_CELLS + 1;
    localparam int P_F   = DIV_CELLS + 2;
    localparam int P_C   = DIV_CELLS + 3;
    localparam int P_N   = P_C + TRIG_STAGES;
    localparam int P_M1  = P_N + 1;
    localparam int P_M2  = P_N + 2;
    localparam int NSB   = P_N + 3;

    // configuration registers
    logic [30:0]      r_radius;
    logic [CUT_W-1:0] r_h_cuts;
    logic [CUT_W-1:0] r_v_cuts;
    logic [31:0]      r_center_x;
    logic [31:0]      r_center_y;
    logic [31:0]      r_center_z;
    logic [31:0]      r_tint;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= 31'd65536;
            r_h_cuts   <= 10'd16;
            r_v_cuts   <= 10'd8;
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_tint     <= 32'hFFFF_FFFF;
        end else if (w_wr) begin
            case (w_idx)
                REG_RADIUS:   r_radius   <= pwdata[30:0];
                REG_H_CUTS:   r_h_cuts   <= pwdata[CUT_W-1:0];
                REG_V_CUTS:   r_v_cuts   <= pwdata[CUT_W-1:0];
                REG_CENTER_X: r_center_x <= pwdata;
                REG_CENTER_Y: r_center_y <= pwdata;
                REG_CENTER_Z: r_center_z <= pwdata;
                REG_TINT:     r_tint     <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RADIUS:   prdata = {1'b0, r_radius};
            REG_H_CUTS:   prdata = {22'b0, r_h_cuts};
            REG_V_CUTS:   prdata = {22'b0, r_v_cuts};
            REG_CENTER_X: prdata = r_center_x;
            REG_CENTER_Y: prdata = r_center_y;
            REG_CENTER_Z: prdata = r_center_z;
            REG_TINT:     prdata = r_tint;
            default:      prdata = '0;
        endcase
    end

    // clamp cut counts to 1 .. MAX_CUTS-1
    logic [CUT_W-1:0] w_h;
    logic [CUT_W-1:0] w_v;

    always_comb begin
        if (r_h_cuts == '0) begin
            w_h = CUT_W'(1);
        end else if ({22'b0, r_h_cuts} > 32'(MAX_CUTS - 1)) begin
            w_h = CUT_W'(MAX_CUTS - 1);
        end else begin
            w_h = r_h_cuts;
        end
        if (r_v_cuts == '0) begin
            w_v = CUT_W'(1);
        end else if ({22'b0, r_v_cuts} > 32'(MAX_CUTS - 1)) begin
            w_v = CUT_W'(MAX_CUTS - 1);
        end else begin
            w_v = r_v_cuts;
        end
    end

    // output register control
    logic w_adv;
    logic r_ov;
    logic r_pend;

    assign w_adv         = !r_ov || (m_axis_tready && !r_pend);
    assign s_axis_tready = w_adv;

    // entry stage
    logic [CUT_W-1:0] w_ring;
    logic [CUT_W-1:0] w_seg;
    logic [CUT_W:0]   w_h1;
    logic [20:0]      w_prod;
    logic             w_bad;
    t_side            n_sb0;
    t_div             n_div0;
    t_div             r_div0;

    always_comb begin
        w_ring = s_axis_tdata[9:0];
        w_seg  = s_axis_tdata[19:10];
        w_h1   = {1'b0, w_h} + 11'd1;
        w_prod = 21'(w_h1) * 21'(w_ring);
        if (s_axis_tuser) begin
            w_bad = (w_ring >= w_v) || (w_seg >= w_h);
        end else begin
            w_bad = (w_ring > w_v) || (w_seg > w_h);
        end
        n_sb0          = '0;
        n_sb0.valid    = s_axis_tvalid;
        n_sb0.req_type = s_axis_tuser;
        n_sb0.bad      = w_bad;
        n_sb0.i0       = IDX_W'(w_prod + 21'(w_seg));
        n_sb0.i2       = IDX_W'(w_prod + 21'(w_seg) + 21'(w_h1));
        // integer quotient bit; the cells add the fraction bits
        n_div0.q_h   = {{(QUO_W-1){1'b0}}, (w_seg >= w_h)};
        n_div0.q_v   = {{(QUO_W-1){1'b0}}, (w_ring >= w_v)};
        n_div0.rem_h = (w_seg >= w_h) ? CUT_W'(w_seg - w_h) : w_seg;
        n_div0.rem_v = (w_ring >= w_v) ? CUT_W'(w_ring - w_v) : w_ring;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_div0 <= n_div0;
        end
    end

    // divider chain
    t_div w_div [0:DIV_CELLS];

    assign w_div[0] = r_div0;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        usp_div_cell u_div_cell (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_den_h (w_h),
            .i_den_v (w_v),
            .i_div   (w_div[g]),
            .o_div   (w_div[g+1])
        );
    end

    // angle stage: round the quotients into binary angles and texture coordinates
    logic [QUO_W-1:0] w_qh;
    logic [QUO_W-1:0] w_qv;
    logic [QUO_W:0]   w_az_full;
    logic [QUO_W-1:0] w_d_full;
    logic [31:0]      w_az;
    logic [31:0]      w_elev;
    logic [TEX_W+1:0] w_tu_full;
    logic [TEX_W+1:0] w_tv_full;
    logic [31:0]      r_az;
    logic [31:0]      r_elev;

    always_comb begin
        w_qh      = w_div[DIV_CELLS].q_h;
        w_qv      = w_div[DIV_CELLS].q_v;
        w_az_full = ({1'b0, w_qh} + 35'd1) >> 1;
        w_az      = w_az_full[31:0];
        w_d_full  = ({1'b0, w_qv[QUO_W-1:1]} + 34'd1) >> 1;
        w_elev    = 32'(QUARTER_TURN - w_d_full);
        w_tu_full = ({1'b0, w_qh[QUO_W-1:16]} + 19'd1) >> 1;
        w_tv_full = ({1'b0, w_qv[QUO_W-1:16]} + 19'd1) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_az   <= w_az;
            r_elev <= w_elev;
        end
    end

    // fold stage: bring both angles into [-1/4, +1/4] turn
    logic signed [ROT_W-1:0] w_se;
    logic signed [ROT_W-1:0] w_sa;
    logic [ROT_W-1:0]        w_ze;
    logic [ROT_W-1:0]        w_za;
    logic                    w_neg_e;
    logic                    w_neg_a;
    logic [ROT_W-1:0]        r_ze;
    logic [ROT_W-1:0]        r_za;

    always_comb begin
        w_se = $signed({{2{r_elev[31]}}, r_elev});
        w_sa = $signed({{2{r_az[31]}}, r_az});
        w_neg_e = 1'b1;
        w_neg_a = 1'b1;
        if (w_se > $signed(QUARTER_TURN)) begin
            w_ze = w_se - $signed(HALF_TURN);
        end else if (w_se < -$signed(QUARTER_TURN)) begin
            w_ze = w_se + $signed(HALF_TURN);
        end else begin
            w_ze    = w_se;
            w_neg_e = 1'b0;
        end
        if (w_sa > $signed(QUARTER_TURN)) begin
            w_za = w_sa - $signed(HALF_TURN);
        end else if (w_sa < -$signed(QUARTER_TURN)) begin
            w_za = w_sa + $signed(HALF_TURN);
        end else begin
            w_za    = w_sa;
            w_neg_a = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ze <= w_ze;
            r_za <= w_za;
        end
    end

    // CORDIC chain
    t_rot w_rot [0:TRIG_STAGES];

    always_comb begin
        w_rot[0].elev.x = CORDIC_K;
        w_rot[0].elev.y = '0;
        w_rot[0].elev.z = r_ze;
        w_rot[0].azim.x = CORDIC_K;
        w_rot[0].azim.y = '0;
        w_rot[0].azim.z = r_za;
    end

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_rot
        usp_cordic_cell #(
            .STAGE (g)
        ) u_cordic_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rot (w_rot[g]),
            .o_rot (w_rot[g+1])
        );
    end

    // sideband shift line alongside the cells
    t_side r_sb [0:NSB-1];
    t_side n_sb [0:NSB-1];

    always_comb begin
        n_sb[0] = n_sb0;
        for (int p = 1; p < NSB; p++) begin
            n_sb[p] = r_sb[p-1];
        end
        n_sb[P_A].tex_u = w_tu_full[TEX_W-1:0];
        n_sb[P_A].tex_v = w_tv_full[TEX_W-1:0];
        n_sb[P_F].neg_e = w_neg_e;
        n_sb[P_F].neg_a = w_neg_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NSB; p++) begin
                r_sb[p].valid <= 1'b0;
            end
        end else if (w_adv) begin
            for (int p = 0; p < NSB; p++) begin
                r_sb[p] <= n_sb[p];
            end
        end
    end

    // sign-restore stage
    logic signed [ROT_W-1:0] r_ce;
    logic signed [ROT_W-1:0] r_sne;
    logic signed [ROT_W-1:0] r_ca;
    logic signed [ROT_W-1:0] r_sna;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ce  <= r_sb[P_N-1].neg_e ? -$signed(w_rot[TRIG_STAGES].elev.x)
                                       : $signed(w_rot[TRIG_STAGES].elev.x);
            r_sne <= r_sb[P_N-1].neg_e ? -$signed(w_rot[TRIG_STAGES].elev.y)
                                       : $signed(w_rot[TRIG_STAGES].elev.y);
            r_ca  <= r_sb[P_N-1].neg_a ? -$signed(w_rot[TRIG_STAGES].azim.x)
                                       : $signed(w_rot[TRIG_STAGES].azim.x);
            r_sna <= r_sb[P_N-1].neg_a ? -$signed(w_rot[TRIG_STAGES].azim.y)
                                       : $signed(w_rot[TRIG_STAGES].azim.y);
        end
    end

    // first product stage: xy = r*cos(elev), z = r*sin(elev)
    logic signed [65:0]      w_pxy;
    logic signed [65:0]      w_pz;
    logic signed [ROT_W-1:0] r_xy;
    logic signed [35:0]      r_z0;
    logic signed [ROT_W-1:0] r_ca1;
    logic signed [ROT_W-1:0] r_sa1;

    always_comb begin
        w_pxy = 66'($signed({1'b0, r_radius})) * 66'(r_ce) + 66'sd536870912;
        w_pz  = 66'($signed({1'b0, r_radius})) * 66'(r_sne) + 66'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_xy  <= w_pxy[63:30];
            r_z0  <= w_pz[65:30];
            r_ca1 <= r_ca;
            r_sa1 <= r_sna;
        end
    end

    // second product stage: x = xy*cos(az), y = xy*sin(az)
    logic signed [67:0] w_px;
    logic signed [67:0] w_py;
    logic signed [35:0] r_x0;
    logic signed [35:0] r_y0;
    logic signed [35:0] r_z1;

    always_comb begin
        w_px = 68'(r_xy) * 68'(r_ca1) + 68'sd536870912;
        w_py = 68'(r_xy) * 68'(r_sa1) + 68'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x0 <= w_px[65:30];
            r_y0 <= w_py[65:30];
            r_z1 <= r_z0;
        end
    end

    // add the centre and saturate to 32 bits
    function automatic logic [31:0] sat_add(input logic signed [35:0] a,
                                            input logic [31:0] c);
        logic signed [36:0] s;
        s = 37'(a) + 37'($signed(c));
        if (s > 37'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (s < -37'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return s[31:0];
        end
    endfunction

    // output register
    t_side            w_last_sb;
    logic [31:0]      r_pos_x;
    logic [31:0]      r_pos_y;
    logic [31:0]      r_pos_z;
    logic [TEX_W-1:0] r_tex_u;
    logic [TEX_W-1:0] r_tex_v;
    logic [31:0]      r_color;
    logic [IDX_W-1:0] r_tri_a;
    logic [IDX_W-1:0] r_tri_b;
    logic [IDX_W-1:0] r_tri_c;
    logic             r_last;
    logic             r_bad;
    logic [IDX_W-1:0] r_hold_i0;
    logic [IDX_W-1:0] r_hold_i2;

    assign w_last_sb = r_sb[P_M2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else if (r_ov && r_pend && m_axis_tready) begin
            // second triangle of a quad
            r_pend  <= 1'b0;
            r_tri_a <= r_hold_i0;
            r_tri_b <= r_hold_i2 + 20'd1;
            r_tri_c <= r_hold_i2;
            r_last  <= 1'b1;
        end else if (w_adv) begin
            r_ov      <= w_last_sb.valid;
            r_pend    <= w_last_sb.valid && w_last_sb.req_type && !w_last_sb.bad;
            r_hold_i0 <= w_last_sb.i0;
            r_hold_i2 <= w_last_sb.i2;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_pos_z   <= '0;
            r_tex_u   <= '0;
            r_tex_v   <= '0;
            r_color   <= '0;
            r_tri_a   <= '0;
            r_tri_b   <= '0;
            r_tri_c   <= '0;
            r_last    <= 1'b1;
            r_bad     <= w_last_sb.bad;
            if (!w_last_sb.bad) begin
                if (w_last_sb.req_type) begin
                    r_tri_a <= w_last_sb.i0;
                    r_tri_b <= w_last_sb.i0 + 20'd1;
                    r_tri_c <= w_last_sb.i2 + 20'd1;
                    r_last  <= 1'b0;
                end else begin
                    r_pos_x <= sat_add(r_x0, r_center_x);
                    r_pos_y <= sat_add(r_y0, r_center_y);
                    r_pos_z <= sat_add(r_z1, r_center_z);
                    r_tex_u <= w_last_sb.tex_u;
                    r_tex_v <= w_last_sb.tex_v;
                    r_color <= r_tint;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b0, r_tri_c, r_tri_b, r_tri_a, r_color, r_tex_v, r_tex_u,
                            r_pos_z, r_pos_y, r_pos_x};
    assign m_axis_tuser  = r_bad;
    assign m_axis_tlast  = r_last;

    // hold new requests while the second triangle of a quad is outstanding
    a_pend_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_ov && !s_axis_tready))
        else $error("input taken while a quad half is pending");

    a_second_half_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_pend && m_axis_tready) |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tuser))
        else $error("second triangle word missing or malformed");

    a_bad_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("bad request word carries data");

    a_first_half_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_pend) |-> !m_axis_tlast)
        else $error("first triangle word flagged last");

endmodule
